// ===== rtl/smfd_pkg.sv =====
package smfd_pkg;

    // Sync byte detection
    localparam logic [7:0] SYNC_MASK    = 8'hF8;
    localparam logic [7:0] SYNC_VALUE   = 8'h80;
    localparam logic [7:0] BUTTON_LINES = 8'h07;

    // Number of button lines carried in a sync byte
    localparam int BUTTON_LINE_COUNT    = 3;
    localparam int DEFAULT_BUTTON_COUNT = 3;

    // Byte position within a frame
    localparam logic [2:0] POS_HUNT = 3'd0;
    localparam logic [2:0] POS_X1   = 3'd1;
    localparam logic [2:0] POS_Y1   = 3'd2;
    localparam logic [2:0] POS_X2   = 3'd3;
    localparam logic [2:0] POS_Y2   = 3'd4;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_MOTION  = 2'd2
    } smfd_kind_t;

    // Decoded frame handed from the framer to the event emitter
    typedef struct packed {
        logic [BUTTON_LINE_COUNT-1:0] change;
        logic [BUTTON_LINE_COUNT-1:0] pressed;
        logic                         motion;
        logic signed [8:0]            dx;
        logic signed [8:0]            dy;
    } smfd_frame_t;

    // Reorder inverted button lines into button order
    function automatic logic [2:0] button_order(input logic [2:0] lines);
        logic [2:0] result;
        begin
            unique case (lines)
                3'd0:    result = 3'd0;
                3'd1:    result = 3'd4;
                3'd2:    result = 3'd1;
                3'd3:    result = 3'd5;
                3'd4:    result = 3'd2;
                3'd5:    result = 3'd6;
                3'd6:    result = 3'd3;
                3'd7:    result = 3'd7;
                default: result = 3'd0;
            endcase
            return result;
        end
    endfunction

endpackage

// ===== rtl/smfd_framer.sv =====
module smfd_framer
    import smfd_pkg::*;
#(
    parameter int BUTTON_COUNT = DEFAULT_BUTTON_COUNT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        pend_empty,
    output logic        frame_load,
    output smfd_frame_t frame
);

    localparam logic [BUTTON_LINE_COUNT-1:0] BUTTON_MASK =
        BUTTON_LINE_COUNT'((1 << BUTTON_COUNT) - 1);

    logic                         enable_reg;
    logic                         byte_valid_reg;
    logic                         byte_valid_next;
    logic [7:0]                   byte_reg;
    logic [2:0]                   pos_reg;
    logic [2:0]                   pos_next;
    logic [2:0]                   buttons_reg;
    logic [2:0]                   buttons_next;
    logic [2:0]                   held_reg;
    logic [2:0]                   held_next;
    logic [7:0]                   x1_reg;
    logic [7:0]                   y1_reg;
    logic [7:0]                   x2_reg;
    logic                         is_final;
    logic                         go;
    logic                         accept;
    logic [BUTTON_LINE_COUNT-1:0] change;

    // Final byte waits while earlier events drain
    assign is_final = enable_reg && (pos_reg == POS_Y2);
    assign go       = byte_valid_reg && (!is_final || pend_empty);
    assign in_stall = byte_valid_reg && !go;
    assign accept   = in_valid && !in_stall;

    assign change = (buttons_reg ^ held_reg) & BUTTON_MASK;

    // Build the decoded frame from stored bytes and the current byte
    always_comb
    begin
        frame.change  = change;
        frame.pressed = buttons_reg;
        frame.dx      = $signed({x1_reg[7], x1_reg}) + $signed({x2_reg[7], x2_reg});
        frame.dy      = $signed({y1_reg[7], y1_reg}) + $signed({byte_reg[7], byte_reg});
        frame.motion  = (frame.dx != 9'sd0) || (frame.dy != 9'sd0);
    end

    assign frame_load = go && is_final;

    // Advance frame position and button state
    always_comb
    begin
        pos_next        = pos_reg;
        buttons_next    = buttons_reg;
        held_next       = held_reg;
        byte_valid_next = accept ? 1'b1 : (go ? 1'b0 : byte_valid_reg);
        if (go && enable_reg)
        begin
            if (pos_reg == POS_HUNT)
            begin
                if ((byte_reg & SYNC_MASK) == SYNC_VALUE)
                begin
                    buttons_next = button_order(~byte_reg[2:0] & BUTTON_LINES[2:0]);
                    pos_next     = POS_X1;
                end
            end
            else if (pos_reg == POS_Y2)
            begin
                pos_next  = POS_HUNT;
                held_next = held_reg ^ change;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            byte_valid_reg <= 1'b0;
            pos_reg        <= POS_HUNT;
            buttons_reg    <= 3'd0;
            held_reg       <= 3'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            byte_valid_reg <= byte_valid_next;
            pos_reg        <= pos_next;
            buttons_reg    <= buttons_next;
            held_reg       <= held_next;
        end
    end

    // Capture the request byte and the data bytes of a frame
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
        if (go && enable_reg)
        begin
            case (pos_reg)
                POS_X1:  x1_reg <= byte_reg;
                POS_Y1:  y1_reg <= byte_reg;
                POS_X2:  x2_reg <= byte_reg;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/smfd_emitter.sv =====
module smfd_emitter
    import smfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_load,
    input  smfd_frame_t       frame,
    output logic              pend_empty,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        event_kind,
    output logic [1:0]        button_index,
    output logic signed [8:0] delta_x,
    output logic signed [8:0] delta_y,
    output logic              last_of_frame
);

    logic [BUTTON_LINE_COUNT-1:0] chg_reg;
    logic [BUTTON_LINE_COUNT-1:0] chg_next;
    logic [BUTTON_LINE_COUNT-1:0] pressed_reg;
    logic                         mot_reg;
    logic                         mot_next;
    logic signed [8:0]            dx_reg;
    logic signed [8:0]            dy_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         pop;
    logic                         pick_found;
    logic [1:0]                   pick_idx;
    smfd_kind_t                   kind_next;
    logic [1:0]                   idx_next;
    logic signed [8:0]            ox_next;
    logic signed [8:0]            oy_next;
    logic                         last_next;
    smfd_kind_t                   kind_reg;
    logic [1:0]                   idx_reg;
    logic signed [8:0]            ox_reg;
    logic signed [8:0]            oy_reg;
    logic                         last_reg;

    assign pend_empty = (chg_reg == '0) && !mot_reg;
    assign pop        = !pend_empty && (!out_valid_reg || !out_stall);

    // Pick the lowest changed button
    always_comb
    begin
        pick_found = 1'b0;
        pick_idx   = 2'd0;
        for (int j = BUTTON_LINE_COUNT - 1; j >= 0; j--)
        begin
            if (chg_reg[j])
            begin
                pick_found = 1'b1;
                pick_idx   = 2'(j);
            end
        end
    end

    // Form the next event and drop it from the pending set
    always_comb
    begin
        chg_next  = chg_reg;
        mot_next  = mot_reg;
        kind_next = KIND_MOTION;
        idx_next  = 2'd0;
        ox_next   = dx_reg;
        oy_next   = dy_reg;
        if (pick_found)
        begin
            kind_next          = pressed_reg[pick_idx] ? KIND_PRESS : KIND_RELEASE;
            idx_next           = pick_idx;
            ox_next            = 9'sd0;
            oy_next            = 9'sd0;
            chg_next[pick_idx] = 1'b0;
        end
        else
        begin
            mot_next = 1'b0;
        end
        last_next = (chg_next == '0) && !mot_next;

        if (frame_load)
        begin
            chg_next = frame.change;
            mot_next = frame.motion;
        end
        else if (!pop)
        begin
            chg_next = chg_reg;
            mot_next = mot_reg;
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Hold pending set and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chg_reg       <= '0;
            mot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chg_reg       <= chg_next;
            mot_reg       <= mot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture frame payload and result payload
    always_ff @(posedge clk)
    begin
        if (frame_load)
        begin
            pressed_reg <= frame.pressed;
            dx_reg      <= frame.dx;
            dy_reg      <= frame.dy;
        end
        if (pop)
        begin
            kind_reg <= kind_next;
            idx_reg  <= idx_next;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            last_reg <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = kind_reg;
    assign button_index  = idx_reg;
    assign delta_x       = ox_reg;
    assign delta_y       = oy_reg;
    assign last_of_frame = last_reg;

endmodule

// ===== rtl/serial_mouse_frame_decoder.sv =====
// Path: input byte register, then pending event set, then output register.
// Events of one frame follow one per cycle, at most four, while out_stall is low.
// Throughput: one byte per cycle; a frame's last byte waits in the input register
// until the event queue of the previous frame has drained.
// Reset: decoder disabled, hunting for sync, all buttons released, no request pending.
module serial_mouse_frame_decoder
    import smfd_pkg::*;
#(
    parameter int BUTTON_COUNT = DEFAULT_BUTTON_COUNT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        event_kind,
    output logic [1:0]        button_index,
    output logic signed [8:0] delta_x,
    output logic signed [8:0] delta_y,
    output logic              last_of_frame
);

    logic        pend_empty;
    logic        frame_load;
    smfd_frame_t frame;

    // Frame assembly and button tracking
    smfd_framer #(
        .BUTTON_COUNT(BUTTON_COUNT)
    ) u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .pend_empty (pend_empty),
        .frame_load (frame_load),
        .frame      (frame)
    );

    // Event sequencing into the output register
    smfd_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_load    (frame_load),
        .frame         (frame),
        .pend_empty    (pend_empty),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .button_index  (button_index),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .last_of_frame (last_of_frame)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import smfd_pkg::*;

    localparam int NUM_BUTTONS  = 3;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 260;

    // Inverted button lines to button bits
    localparam logic [2:0] LINE_TO_BUTTONS [8] = '{3'd0, 3'd4, 3'd1, 3'd5,
                                                  3'd2, 3'd6, 3'd3, 3'd7};

    typedef struct {
        smfd_kind_t        kind;
        logic [1:0]        button;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
        logic              last;
    } mouse_event_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        rx_byte = 8'h00;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        event_kind;
    logic [1:0]        button_index;
    logic signed [8:0] delta_x;
    logic signed [8:0] delta_y;
    logic              last_of_frame;

    // Decoder state as the testbench sees it
    logic              dec_enable = 1'b0;
    logic [2:0]        frame_pos = POS_HUNT;
    logic [2:0]        frame_btns = 3'd0;
    logic [2:0]        held_btns = 3'd0;
    logic [7:0]        data_bytes [4];

    mouse_event_t      pending_events [$];
    mouse_event_t      expected_event;
    int                error_count = 0;
    int                stall_cnt = 0;
    logic              in_idle_on = 1'b1;
    logic              out_idle_on = 1'b1;

    serial_mouse_frame_decoder #(
        .BUTTON_COUNT (NUM_BUTTONS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .button_index  (button_index),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .last_of_frame (last_of_frame)
    );

    always #5 clk = ~clk;

    // Work out the events that one accepted byte causes
    task automatic predict_decoded_events(input logic [7:0] b);
        mouse_event_t      frame_events [$];
        mouse_event_t      ev;
        logic signed [8:0] sum_x;
        logic signed [8:0] sum_y;
        logic              now_held;
        if (!dec_enable)
            return;
        if (frame_pos == POS_HUNT)
        begin
            if ((b & SYNC_MASK) == SYNC_VALUE)
            begin
                frame_btns = LINE_TO_BUTTONS[~b[2:0]];
                frame_pos  = POS_X1;
            end
            return;
        end
        data_bytes[2'(frame_pos - 3'd1)] = b;
        if (frame_pos != POS_Y2)
        begin
            frame_pos = frame_pos + 3'd1;
            return;
        end
        frame_pos = POS_HUNT;

        // Button changes in button order
        for (int j = 0; j < NUM_BUTTONS; j++)
        begin
            now_held = frame_btns[j];
            if (now_held != held_btns[j])
            begin
                ev.kind   = now_held ? KIND_PRESS : KIND_RELEASE;
                ev.button = 2'(j);
                ev.dx     = '0;
                ev.dy     = '0;
                ev.last   = 1'b0;
                frame_events.push_back(ev);
                held_btns[j] = now_held;
            end
        end

        // Motion when either sum is nonzero
        sum_x = {data_bytes[0][7], data_bytes[0]} + {data_bytes[2][7], data_bytes[2]};
        sum_y = {data_bytes[1][7], data_bytes[1]} + {data_bytes[3][7], data_bytes[3]};
        if (sum_x != 0 || sum_y != 0)
        begin
            ev.kind   = KIND_MOTION;
            ev.button = 2'd0;
            ev.dx     = sum_x;
            ev.dy     = sum_y;
            ev.last   = 1'b0;
            frame_events.push_back(ev);
        end

        if (frame_events.size() > 0)
            frame_events[frame_events.size() - 1].last = 1'b1;
        foreach (frame_events[i])
            pending_events.push_back(frame_events[i]);
    endtask

    // Send one byte request and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_decoded_events(b);
    endtask

    task automatic send_frame(input logic [7:0] sync, input logic [7:0] x1,
                              input logic [7:0] y1, input logic [7:0] x2,
                              input logic [7:0] y2);
        send_byte(sync);
        send_byte(x1);
        send_byte(y1);
        send_byte(x2);
        send_byte(y2);
    endtask

    // Drop valid, wait for every event, then let the pipeline settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_decoder_enable(input logic value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        dec_enable = value;
    endtask

    // Bytes sent before the decoder is enabled must be ignored
    task automatic test_ignored_while_disabled();
        send_frame(8'h80, 8'h7F, 8'h01, 8'h7F, 8'h01);
        send_byte(8'h55);
        set_decoder_enable(1'b1);
    endtask

    task automatic test_directed_frames();
        // Hunt past bytes that are not sync
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h88);
        // All buttons pressed, largest motion
        send_frame(8'h80, 8'h7F, 8'h7F, 8'h7F, 8'h7F);
        // All buttons released, smallest motion
        send_frame(8'h87, 8'h80, 8'h80, 8'h80, 8'h80);
        // Quiet frame
        send_frame(8'h87, 8'h00, 8'h00, 8'h00, 8'h00);
        // Sync-like data bytes inside a frame, motion in x only
        send_frame(8'h82, 8'h85, 8'h87, 8'h80, 8'h79);
        // Button change only, x sums cancel
        send_frame(8'h86, 8'h01, 8'h00, 8'hFF, 8'h00);
        // Motion in y only
        send_frame(8'h86, 8'h00, 8'h03, 8'h00, 8'h00);
    endtask

    // A partly collected frame resumes after a disabled stretch
    task automatic test_resume_after_disable();
        send_byte(8'h84);
        send_byte(8'h10);
        send_byte(8'h20);
        set_decoder_enable(1'b0);
        send_byte(8'h80);
        send_byte(8'h81);
        send_byte(8'h7F);
        set_decoder_enable(1'b1);
        send_byte(8'h30);
        send_byte(8'h40);
    endtask

    function automatic logic [7:0] pick_data_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'h7F;
            2:       return 8'h80;
            3:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_random_frames();
        int         sent;
        logic [2:0] lines;
        logic       did_disable;
        sent        = 0;
        lines       = 3'b111;
        did_disable = 1'b0;
        while (sent < RANDOM_BYTES)
        begin
            // Reshuffle idling now and then, with some stretches of none
            if ($urandom_range(0, 9) == 0)
            begin
                in_idle_on  = ($urandom_range(0, 2) != 0);
                out_idle_on = ($urandom_range(0, 2) != 0);
            end
            if (!did_disable && sent >= RANDOM_BYTES / 2)
            begin
                did_disable = 1'b1;
                set_decoder_enable(1'b0);
                repeat (8) send_byte(8'($urandom_range(0, 255)));
                set_decoder_enable(1'b1);
            end
            if ($urandom_range(0, 99) < 15)
            begin
                // Noise, which may also open a frame out of step
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end
            else
            begin
                if ($urandom_range(0, 9) < 3)
                    lines = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 7) == 0)
                    send_frame(SYNC_VALUE | 8'(lines), 8'h00, 8'h00, 8'h00, 8'h00);
                else
                    send_frame(SYNC_VALUE | 8'(lines), pick_data_byte(),
                               pick_data_byte(), pick_data_byte(), pick_data_byte());
                sent += 5;
            end
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // Accept events, compare them with the oldest expectation, drive stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    $error("unexpected event: kind %0d button %0d dx %0d dy %0d",
                           event_kind, button_index, delta_x, delta_y);
                    error_count++;
                end
                else
                begin
                    expected_event = pending_events.pop_front();
                    if (event_kind !== expected_event.kind)
                    begin
                        $error("event_kind: expected %0d, actual %0d",
                               expected_event.kind, event_kind);
                        error_count++;
                    end
                    if (button_index !== expected_event.button)
                    begin
                        $error("button_index: expected %0d, actual %0d",
                               expected_event.button, button_index);
                        error_count++;
                    end
                    if (delta_x !== expected_event.dx)
                    begin
                        $error("delta_x: expected %0d, actual %0d",
                               expected_event.dx, delta_x);
                        error_count++;
                    end
                    if (delta_y !== expected_event.dy)
                    begin
                        $error("delta_y: expected %0d, actual %0d",
                               expected_event.dy, delta_y);
                        error_count++;
                    end
                    if (last_of_frame !== expected_event.last)
                    begin
                        $error("last_of_frame: expected %0d, actual %0d",
                               expected_event.last, last_of_frame);
                        error_count++;
                    end
                end
                stall_cnt = out_idle_on ? $urandom_range(0, 19) : 0;
            end
            else if (stall_cnt > 0)
                stall_cnt--;
            else if (out_idle_on && !out_valid && $urandom_range(0, 3) == 0)
                stall_cnt = $urandom_range(0, 19);
            out_stall <= (stall_cnt != 0);
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ignored_while_disabled();
        test_directed_frames();
        test_resume_after_disable();
        test_random_frames();
        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_events.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop for a hung run
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
